### src/dns_a_query_encoder_defines.svh
// ----------------------------------------------------------------------------
// DNS A query encoder assertion macros
// Shorthand for the port-level property checks of the encoder.
// ----------------------------------------------------------------------------
`ifndef DNS_A_QUERY_ENCODER_DEFINES_SVH
`define DNS_A_QUERY_ENCODER_DEFINES_SVH

// same-cycle implication
`define DNSQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dns query encoder port check failed");

// next-cycle implication
`define DNSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dns query encoder port check failed");

`endif

### src/dnsq_pkg.sv
// ----------------------------------------------------------------------------
// DNS query encoder package
// Codes, control word layout and microprogram of the query encoder.
// ----------------------------------------------------------------------------
package dnsq_pkg;

   localparam int MAX_LABEL   = 63;
   localparam int LABEL_DEPTH = 63;
   localparam int LADDR_W     = 6;
   localparam int POS_W       = 7;
   localparam int STEP_W      = 4;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // request selector
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_EMPTY   = 2'd1;
   localparam logic [1:0] FAULT_LONG    = 2'd2;
   localparam logic [1:0] FAULT_OUTSIDE = 2'd3;

   // request class, decided at acceptance
   localparam logic [2:0] KIND_NOP     = 3'd0;
   localparam logic [2:0] KIND_START   = 3'd1;
   localparam logic [2:0] KIND_RESTART = 3'd2;
   localparam logic [2:0] KIND_OUTSIDE = 3'd3;
   localparam logic [2:0] KIND_LONG    = 3'd4;
   localparam logic [2:0] KIND_EMPTY   = 3'd5;
   localparam logic [2:0] KIND_FLUSH   = 3'd6;

   // fixed byte sources
   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_ONE  = 2'd1;
   localparam logic [1:0] SRC_IDHI = 2'd2;
   localparam logic [1:0] SRC_IDLO = 2'd3;

   // sequencing
   localparam logic [1:0] COND_NEXT   = 2'd0;
   localparam logic [1:0] COND_GOTO   = 2'd1;
   localparam logic [1:0] COND_STREAM = 2'd2;

   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ABORT   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_HDR0    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_HDR1    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HDR2    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_HDR3    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_HDR4    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_HDR5    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_F_EMPTY = 4'd8;
   localparam logic [STEP_W-1:0] STEP_F_LONG  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_F_OUT   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_STREAM  = 4'd11;

   typedef struct packed {
      logic              emit;
      logic              stream;
      logic [1:0]        src_a;
      logic [1:0]        src_b;
      logic              two;
      logic              last;
      logic              pend;
      logic [1:0]        fault;
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic      ready;
      uword_type uw;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
      logic stream_last;
   } stat_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] pair_count;
      logic       run_last;
      logic       packet_end;
      logic [1:0] fault;
   } rsp_type;

   // microprogram: one control word per step
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{1'b0, 1'b0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, 1'b0, FAULT_NONE,
            COND_GOTO, STEP_IDLE};
      unique case (step) inside
         STEP_IDLE: begin
            w.emit = 1'b0;
         end
         STEP_ABORT: begin
            w = '{1'b1, 1'b0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, 1'b1, FAULT_OUTSIDE,
                  COND_NEXT, STEP_IDLE};
         end
         STEP_HDR0: begin
            w = '{1'b1, 1'b0, SRC_IDHI, SRC_IDLO, 1'b1, 1'b0, 1'b0, FAULT_NONE,
                  COND_NEXT, STEP_IDLE};
         end
         STEP_HDR1: begin
            w = '{1'b1, 1'b0, SRC_ONE, SRC_ZERO, 1'b1, 1'b0, 1'b0, FAULT_NONE,
                  COND_NEXT, STEP_IDLE};
         end
         STEP_HDR2: begin
            w = '{1'b1, 1'b0, SRC_ZERO, SRC_ONE, 1'b1, 1'b0, 1'b0, FAULT_NONE,
                  COND_NEXT, STEP_IDLE};
         end
         STEP_HDR3, STEP_HDR4: begin
            w = '{1'b1, 1'b0, SRC_ZERO, SRC_ZERO, 1'b1, 1'b0, 1'b0, FAULT_NONE,
                  COND_NEXT, STEP_IDLE};
         end
         STEP_HDR5: begin
            w = '{1'b1, 1'b0, SRC_ZERO, SRC_ZERO, 1'b1, 1'b1, 1'b0, FAULT_NONE,
                  COND_GOTO, STEP_IDLE};
         end
         STEP_F_EMPTY: begin
            w = '{1'b1, 1'b0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b1, 1'b1, FAULT_EMPTY,
                  COND_GOTO, STEP_IDLE};
         end
         STEP_F_LONG: begin
            w = '{1'b1, 1'b0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b1, 1'b1, FAULT_LONG,
                  COND_GOTO, STEP_IDLE};
         end
         STEP_F_OUT: begin
            w = '{1'b1, 1'b0, SRC_ZERO, SRC_ZERO, 1'b0, 1'b1, 1'b1, FAULT_OUTSIDE,
                  COND_GOTO, STEP_IDLE};
         end
         STEP_STREAM: begin
            w = '{1'b1, 1'b1, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, 1'b0, FAULT_NONE,
                  COND_STREAM, STEP_IDLE};
         end
         default: begin
            w.emit = 1'b0;
         end
      endcase
      return w;
   endfunction

   // trailer after the label bytes: root 00, QTYPE 00 01, QCLASS 00 01
   function automatic logic [7:0] tail_byte(input logic [POS_W-1:0] k);
      return (k == 7'd2 || k == 7'd4) ? 8'h01 : 8'h00;
   endfunction

endpackage

### src/dns_a_query_encoder.sv
// ----------------------------------------------------------------------------
// DNS A query encoder
// Turns a stream of start, name character and end requests into the bytes
// of a DNS A-record query, up to two bytes per result.
// ----------------------------------------------------------------------------
// A start request is accepted and then yields six results, one per
// cycle while the result side is ready (seven with the abort result of an
// open packet). A name character is accepted and written to the
// label RAM. A dot or end of name is accepted and then yields
// ceil((n+1)/2) results for a dot or ceil((n+6)/2) for the end, n being the
// label length; the sequencer issues one result per step and the label RAM
// supplies two bytes per step through its two read ports. Fault results take
// one step. A new request is taken only when the sequencer is back at its
// idle step; the result register lets that happen while the last result
// still waits. The label RAM needs no clearing after reset.
module dns_a_query_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // txn_id[15:0], name_char[23:16]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // first_byte[7:0], second_byte[15:8],
                                    // pair_count[17:16], packet_end[18], zero
   output logic [1:0]  rsp_tuser,   // fault[1:0]
   output logic        rsp_tlast    // run_last
);
   import dnsq_pkg::*;

   ctrl_type           ctrl;
   stat_type           stat;
   rsp_type            rsp;
   logic [2:0]         kind;
   logic               ram_wr_en;
   logic [LADDR_W-1:0] ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic [LADDR_W-1:0] ram_rd_addr_a;
   logic [LADDR_W-1:0] ram_rd_addr_b;
   logic [7:0]         ram_rd_data_a;
   logic [7:0]         ram_rd_data_b;

   dnsq_ram #(
      .WIDTH (8),
      .DEPTH (LABEL_DEPTH)
   ) u_label_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   dnsq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .kind      (kind),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   dnsq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_op        (req_tuser),
      .req_txn_id    (req_tdata[15:0]),
      .req_name_char (req_tdata[23:16]),
      .ctrl          (ctrl),
      .kind          (kind),
      .stat          (stat),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr_a (ram_rd_addr_a),
      .ram_rd_addr_b (ram_rd_addr_b),
      .ram_rd_data_a (ram_rd_data_a),
      .ram_rd_data_b (ram_rd_data_b),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp           (rsp)
   );

   assign req_tready = ctrl.ready;
   assign rsp_tdata  = {5'b00000, rsp.packet_end, rsp.pair_count,
                        rsp.second_byte, rsp.first_byte};
   assign rsp_tuser  = rsp.fault;
   assign rsp_tlast  = rsp.run_last;

endmodule

### src/dnsq_ram.sv
// ----------------------------------------------------------------------------
// DNS query encoder RAM
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dnsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### src/dnsq_seq.sv
// ----------------------------------------------------------------------------
// DNS query encoder sequencer
// Step counter over the microprogram, with dispatch on the request class.
// ----------------------------------------------------------------------------
module dnsq_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [2:0]         kind,
   input  dnsq_pkg::stat_type stat,
   output dnsq_pkg::ctrl_type ctrl
);
   import dnsq_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] entry;
   uword_type         uw;

   assign uw         = ucode_rom(step_ff);
   assign ctrl.uw    = uw;
   assign ctrl.ready = (step_ff == STEP_IDLE);

   always_comb begin
      unique case (kind)
         KIND_START:   entry = STEP_HDR0;
         KIND_RESTART: entry = STEP_ABORT;
         KIND_OUTSIDE: entry = STEP_F_OUT;
         KIND_LONG:    entry = STEP_F_LONG;
         KIND_EMPTY:   entry = STEP_F_EMPTY;
         KIND_FLUSH:   entry = STEP_STREAM;
         default:      entry = STEP_IDLE;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (step_ff == STEP_IDLE) begin
         if (req_valid) begin
            step_in = entry;
         end
      end else if (uw.emit && stat.out_free) begin
         unique case (uw.cond)
            COND_NEXT:   step_in = step_ff + 4'd1;
            COND_GOTO:   step_in = uw.target;
            COND_STREAM: step_in = stat.stream_last ? uw.target : step_ff;
            default:     step_in = STEP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### src/dnsq_dp.sv
// ----------------------------------------------------------------------------
// DNS query encoder datapath
// Query state, label write side, byte selection and the result register.
// ----------------------------------------------------------------------------
module dnsq_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [1:0]                   req_op,
   input  logic [15:0]                  req_txn_id,
   input  logic [7:0]                   req_name_char,
   input  dnsq_pkg::ctrl_type           ctrl,
   output logic [2:0]                   kind,
   output dnsq_pkg::stat_type           stat,
   output logic                         ram_wr_en,
   output logic [dnsq_pkg::LADDR_W-1:0] ram_wr_addr,
   output logic [7:0]                   ram_wr_data,
   output logic [dnsq_pkg::LADDR_W-1:0] ram_rd_addr_a,
   output logic [dnsq_pkg::LADDR_W-1:0] ram_rd_addr_b,
   input  logic [7:0]                   ram_rd_data_a,
   input  logic [7:0]                   ram_rd_data_b,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output dnsq_pkg::rsp_type            rsp
);
   import dnsq_pkg::*;

   logic                 active_ff, active_in;
   logic [LADDR_W-1:0]   len_ff, len_in;
   logic [LADDR_W-1:0]   flen_ff, flen_in;
   logic                 end_ff, end_in;
   logic [15:0]          id_ff, id_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 fire;
   logic                 store;
   logic                 emit_go;
   logic [POS_W-1:0]     n_ext;
   logic [POS_W-1:0]     total;
   logic [POS_W-1:0]     remain;
   logic [POS_W-1:0]     pos_b;
   logic [POS_W-1:0]     addr_a;
   logic                 s_two;
   logic                 s_last;
   logic [7:0]           byte_a;
   logic [7:0]           byte_b;
   logic [7:0]           fix_a;
   logic [7:0]           fix_b;

   assign fire = req_valid && ctrl.ready;

   // classify the request against the query state
   always_comb begin
      if (req_op == OP_START) begin
         kind = active_ff ? KIND_RESTART : KIND_START;
      end else if (req_op != OP_CHAR && req_op != OP_END) begin
         kind = KIND_NOP;
      end else if (!active_ff) begin
         kind = KIND_OUTSIDE;
      end else if (req_op == OP_CHAR && req_name_char != DOT_CHAR) begin
         kind = (len_ff >= 6'(MAX_LABEL)) ? KIND_LONG : KIND_NOP;
      end else if (len_ff == '0) begin
         kind = KIND_EMPTY;
      end else begin
         kind = KIND_FLUSH;
      end
   end

   assign store = fire && active_ff && req_op == OP_CHAR && req_name_char != DOT_CHAR &&
                  len_ff < 6'(MAX_LABEL);

   assign ram_wr_en   = store;
   assign ram_wr_addr = len_ff;
   assign ram_wr_data = req_name_char;

   assign emit_go = ctrl.uw.emit && stat.out_free;

   // query state changes all happen at acceptance
   always_comb begin
      active_in = active_ff;
      len_in    = len_ff;
      flen_in   = flen_ff;
      end_in    = end_ff;
      id_in     = id_ff;
      if (fire) begin
         case (kind) inside
            KIND_START, KIND_RESTART: begin
               active_in = 1'b1;
               len_in    = '0;
               id_in     = req_txn_id;
            end
            KIND_LONG, KIND_EMPTY: begin
               active_in = 1'b0;
               len_in    = '0;
            end
            KIND_FLUSH: begin
               flen_in = len_ff;
               end_in  = (req_op == OP_END);
               len_in  = '0;
               if (req_op == OP_END) begin
                  active_in = 1'b0;
               end
            end
            default: begin
               if (store) begin
                  len_in = len_ff + 6'd1;
               end
            end
         endcase
      end
   end

   // stream position: restart at acceptance, advance one pair per result
   always_comb begin
      pos_in = pos_ff;
      if (fire) begin
         pos_in = '0;
      end else if (emit_go && ctrl.uw.stream) begin
         pos_in = pos_ff + 7'd2;
      end
   end

   // read addresses follow the next position so the data lines up with pos_ff
   assign addr_a        = pos_in - 7'd1;
   assign ram_rd_addr_a = (addr_a > 7'(LABEL_DEPTH - 1)) ? '0 : addr_a[LADDR_W-1:0];
   assign ram_rd_addr_b = (pos_in > 7'(LABEL_DEPTH - 1)) ? '0 : pos_in[LADDR_W-1:0];

   assign n_ext  = {1'b0, flen_ff};
   assign total  = n_ext + (end_ff ? 7'd6 : 7'd1);
   assign remain = total - pos_ff;
   assign s_two  = (remain >= 7'd2);
   assign s_last = (remain <= 7'd2);
   assign pos_b  = pos_ff + 7'd1;

   always_comb begin
      if (pos_ff == '0) begin
         byte_a = {2'b00, flen_ff};
      end else if (pos_ff <= n_ext) begin
         byte_a = ram_rd_data_a;
      end else begin
         byte_a = tail_byte(pos_ff - n_ext - 7'd1);
      end
      if (pos_b <= n_ext) begin
         byte_b = ram_rd_data_b;
      end else begin
         byte_b = tail_byte(pos_b - n_ext - 7'd1);
      end
   end

   always_comb begin
      case (ctrl.uw.src_a)
         SRC_ONE:  fix_a = 8'h01;
         SRC_IDHI: fix_a = id_ff[15:8];
         SRC_IDLO: fix_a = id_ff[7:0];
         default:  fix_a = 8'h00;
      endcase
      case (ctrl.uw.src_b)
         SRC_ONE:  fix_b = 8'h01;
         SRC_IDHI: fix_b = id_ff[15:8];
         SRC_IDLO: fix_b = id_ff[7:0];
         default:  fix_b = 8'h00;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (emit_go) begin
         if (ctrl.uw.stream) begin
            rsp_in.first_byte  = byte_a;
            rsp_in.second_byte = s_two ? byte_b : 8'h00;
            rsp_in.pair_count  = s_two ? 2'd2 : 2'd1;
            rsp_in.run_last    = s_last;
            rsp_in.packet_end  = s_last && end_ff;
            rsp_in.fault       = FAULT_NONE;
         end else begin
            rsp_in.first_byte  = fix_a;
            rsp_in.second_byte = ctrl.uw.two ? fix_b : 8'h00;
            rsp_in.pair_count  = ctrl.uw.two ? 2'd2 : 2'd1;
            rsp_in.run_last    = ctrl.uw.last;
            rsp_in.packet_end  = ctrl.uw.pend;
            rsp_in.fault       = ctrl.uw.fault;
         end
      end
   end

   assign stat.out_free    = !rsp_valid_ff || rsp_ready;
   assign stat.stream_last = s_last;

   assign rsp_valid_in = emit_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flen_ff <= flen_in;
      end_ff  <= end_in;
      id_ff   <= id_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### src/dnsq_checker.sv
// ----------------------------------------------------------------------------
// DNS query encoder checker
// Port-level properties of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dns_a_query_encoder_defines.svh"

module dnsq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import dnsq_pkg::*;

   // a stalled result holds
   `DNSQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a fault result is a single byte that ends the packet
   `DNSQ_ASSERT_SAME(a_fault_shape, clock, reset, rsp_tvalid && rsp_tuser != FAULT_NONE, rsp_tdata[18] && rsp_tdata[17:16] == 2'd1 && rsp_tdata[15:0] == 16'h0000)

   // a clean packet end closes the run of its request
   `DNSQ_ASSERT_SAME(a_end_last, clock, reset, rsp_tvalid && rsp_tdata[18] && rsp_tuser == FAULT_NONE, rsp_tlast)

   // a single-byte result carries a zero second byte
   `DNSQ_ASSERT_SAME(a_single_zero, clock, reset, rsp_tvalid && rsp_tdata[17:16] != 2'd2, rsp_tdata[17:16] == 2'd1 && rsp_tdata[15:8] == 8'h00)

endmodule

bind dns_a_query_encoder dnsq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
